// File: design/otadfb_pkg.sv
// Package for the download data frame builder: field widths, frame constants and shared types.
`timescale 1ns / 1ps

package otadfb_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int SUM_W   = 16;
    localparam int IDX_W   = 3;

    localparam int MAX_PAYLOAD_DEF = 512;

    // Fixed frame bytes.
    localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'hEE;
    localparam logic [BYTE_W-1:0] ID_BYTE    = 8'hB6;
    localparam logic [BYTE_W-1:0] CMD_H_BYTE = 8'h88;
    localparam logic [BYTE_W-1:0] CMD_L_BYTE = 8'h22;
    localparam logic [BYTE_W-1:0] EOF_A_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] EOF_B_BYTE = 8'hFC;
    localparam logic [SUM_W-1:0]  LEN_OFFSET = 16'd5;

    // Byte positions inside the header.
    localparam logic [IDX_W-1:0] HI_SOF   = 3'd0;
    localparam logic [IDX_W-1:0] HI_ID    = 3'd1;
    localparam logic [IDX_W-1:0] HI_LEN_H = 3'd2;
    localparam logic [IDX_W-1:0] HI_LEN_L = 3'd3;
    localparam logic [IDX_W-1:0] HI_CMD_H = 3'd4;
    localparam logic [IDX_W-1:0] HI_CMD_L = 3'd5;
    localparam logic [IDX_W-1:0] HI_SEQ   = 3'd6;

    // Byte positions inside the trailer.
    localparam logic [IDX_W-1:0] TI_CK_H  = 3'd0;
    localparam logic [IDX_W-1:0] TI_CK_L  = 3'd1;
    localparam logic [IDX_W-1:0] TI_EOF_0 = 3'd2;
    localparam logic [IDX_W-1:0] TI_EOF_1 = 3'd3;
    localparam logic [IDX_W-1:0] TI_EOF_2 = 3'd4;
    localparam logic [IDX_W-1:0] TI_EOF_3 = 3'd5;

    typedef enum logic [2:0] {
        PH_HDR  = 3'b001,
        PH_DATA = 3'b010,
        PH_TAIL = 3'b100
    } t_phase;

    // One accepted input word.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] sequence_req;
        logic [LEN_W-1:0]  payload_length;
    } t_item;

    // One produced frame byte with its flags.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_item;
        logic              end_of_frame;
    } t_emit;

endpackage

// File: design/otadfb_seq.sv
// Frame sequencer: walks header, payload and trailer one byte per step and keeps the checksum.
`timescale 1ns / 1ps

module otadfb_seq #(
    parameter int MAX_PAYLOAD = otadfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  otadfb_pkg::t_item  i_item,
    output otadfb_pkg::t_emit  o_emit
);
    import otadfb_pkg::*;

    localparam logic [LEN_W:0] MaxLen = (LEN_W+1)'(MAX_PAYLOAD);

    t_phase              r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [LEN_W-1:0]    r_remaining, n_remaining;
    logic [SUM_W-1:0]    r_sum, n_sum;

    logic [LEN_W-1:0]    len_sat;
    logic [SUM_W-1:0]    frame_len;
    logic [SUM_W-1:0]    check;
    logic [BYTE_W-1:0]   byte_val;
    logic                last_val;
    logic                eof_val;

    assign len_sat   = ({1'b0, i_item.payload_length} > MaxLen) ? MaxLen[LEN_W-1:0]
                                                                 : i_item.payload_length;
    assign frame_len = LEN_OFFSET + SUM_W'(len_sat);
    assign check     = ~r_sum;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_remaining = r_remaining;
        n_sum       = r_sum;
        byte_val    = '0;
        last_val    = 1'b0;
        eof_val     = 1'b0;
        case (r_phase)
            PH_HDR: begin
                case (r_idx)
                    HI_SOF:   byte_val = SOF_BYTE;
                    HI_ID:    byte_val = ID_BYTE;
                    HI_LEN_H: byte_val = frame_len[SUM_W-1:BYTE_W];
                    HI_LEN_L: byte_val = frame_len[BYTE_W-1:0];
                    HI_CMD_H: byte_val = CMD_H_BYTE;
                    HI_CMD_L: byte_val = CMD_L_BYTE;
                    HI_SEQ:   byte_val = i_item.sequence_req;
                    default:  byte_val = '0;
                endcase
                // The start byte is outside the checksum and starts a fresh sum.
                if (r_idx == HI_SOF) begin
                    n_sum = '0;
                end else begin
                    n_sum = r_sum + SUM_W'(byte_val);
                end
                if (r_idx == HI_SEQ) begin
                    n_idx = '0;
                    if (len_sat == '0) begin
                        n_phase = PH_TAIL;
                    end else begin
                        n_phase     = PH_DATA;
                        n_remaining = len_sat;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            PH_DATA: begin
                byte_val = i_item.payload_byte;
                n_sum    = r_sum + SUM_W'(byte_val);
                if (r_remaining <= LEN_W'(1)) begin
                    n_phase = PH_TAIL;
                    n_idx   = '0;
                end else begin
                    n_remaining = r_remaining - 1'b1;
                    last_val    = 1'b1;
                end
            end
            PH_TAIL: begin
                case (r_idx)
                    TI_CK_H:  byte_val = check[SUM_W-1:BYTE_W];
                    TI_CK_L:  byte_val = check[BYTE_W-1:0];
                    TI_EOF_0: byte_val = EOF_A_BYTE;
                    TI_EOF_1: byte_val = EOF_B_BYTE;
                    TI_EOF_2: byte_val = EOF_A_BYTE;
                    TI_EOF_3: byte_val = EOF_A_BYTE;
                    default:  byte_val = '0;
                endcase
                if (r_idx == TI_EOF_3) begin
                    last_val    = 1'b1;
                    eof_val     = 1'b1;
                    n_phase     = PH_HDR;
                    n_idx       = '0;
                    n_sum       = '0;
                    n_remaining = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_phase = PH_HDR;
                n_idx   = '0;
            end
        endcase
    end

    assign o_emit.out_byte     = byte_val;
    assign o_emit.last_of_item = last_val;
    assign o_emit.end_of_frame = eof_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_idx       <= '0;
            r_remaining <= '0;
            r_sum       <= '0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
        end
    end

    // The payload phase always has at least one byte left to send.
    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != '0))
        else $error("payload phase entered with no bytes left");

    // A frame always starts from a cleared checksum.
    a_idle_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR && r_idx == HI_SOF) |-> (r_sum == '0))
        else $error("checksum not cleared between frames");

    // The trailer index never runs past the final trailer byte.
    a_tail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAIL) |-> (r_idx <= TI_EOF_3))
        else $error("trailer index out of range");

    // A frame ends only on a byte that also closes its word.
    a_eof_closes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_emit.end_of_frame) |-> o_emit.last_of_item)
        else $error("end of frame without end of word");

endmodule

// File: design/ota_data_frame_builder_unit.sv
// Top level of the download data frame builder: word register, sequencer and output register.
`timescale 1ns / 1ps

// This block turns a stream of payload words into serial download data frames, one frame
// byte per output word. The first input word of a frame carries the payload length and the
// sequence byte; the block then sends the header EE B6, the big-endian frame length (five
// plus the payload length, which is first limited to MAX_PAYLOAD), 88 22 and the sequence
// byte, followed by that word's payload byte. Every later word adds one payload byte. After
// the last payload byte come the checksum (0xFFFF minus the 16-bit sum of all bytes from B6
// through the last payload byte, high byte first) and the trailer FF FC FF FF. A zero length
// frame is sent whole from a single word whose payload byte is ignored. o_last_of_item marks
// the final byte caused by each input word and o_end_of_frame marks the last trailer byte.
// Timing: the sequencer produces one frame byte per cycle while the output is not stalled,
// so a middle payload word yields one byte and the block takes a new word every cycle in
// that stretch. The first word of a frame yields eight bytes (seven header bytes and its
// payload byte), the last word yields seven (payload byte plus six trailer bytes), a
// one-byte frame yields fourteen and a zero length frame thirteen. An accepted word is
// held in the input word register and its bytes pass through the output register.
module ota_data_frame_builder_unit #(
    parameter int MAX_PAYLOAD = otadfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [otadfb_pkg::BYTE_W-1:0]   i_payload_byte,
    input  logic [otadfb_pkg::BYTE_W-1:0]   i_sequence_req,
    input  logic [otadfb_pkg::LEN_W-1:0]    i_payload_length,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [otadfb_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                            o_last_of_item,
    output logic                            o_end_of_frame
);
    import otadfb_pkg::*;

    logic   r_item_valid, n_item_valid;
    t_item  r_item;
    logic   r_out_valid;
    t_emit  r_out;
    t_emit  emit;

    logic   out_ready;
    logic   go;
    logic   word_done;
    logic   in_accept;

    // The output register can take a byte when it is empty or being drained this cycle.
    assign out_ready = !r_out_valid || !i_out_stall;
    // The sequencer advances one byte whenever a word is held and the byte has a place to go.
    assign go        = r_item_valid && out_ready;
    // The held word is finished when its final byte moves into the output register.
    assign word_done = go && emit.last_of_item;

    // A new word is taken when the holding register is empty or frees up in this cycle.
    assign o_in_stall = r_item_valid && !word_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_item_valid = r_item_valid;
        if (in_accept) begin
            n_item_valid = 1'b1;
        end else if (word_done) begin
            n_item_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_valid <= n_item_valid;
            if (out_ready) begin
                r_out_valid <= go;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.payload_byte   <= i_payload_byte;
            r_item.sequence_req   <= i_sequence_req;
            r_item.payload_length <= i_payload_length;
        end
        if (go) begin
            r_out <= emit;
        end
    end

    otadfb_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_item),
        .o_emit  (emit)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_last_of_item = r_out.last_of_item;
    assign o_end_of_frame = r_out.end_of_frame;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the download data frame builder: stimulus, frame predictor and checks.
`timescale 1ns / 1ps

// The testbench drives payload words into the frame builder and predicts every frame byte
// that each accepted word must produce. It keeps its own copy of the builder state: whether
// a frame is open, how many payload bytes are still owed, and the running 16-bit sum from
// the ID byte on. Each accepted output word is compared field by field with the oldest
// predicted byte. The run covers zero-length and one-byte frames, a length above the
// maximum that must saturate, long output stalls that back the block up into its input,
// a sender pause until the output drains, and a stretch of random frames.
module tb_top;

    import otadfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
    localparam int LONG_HOLD      = 300;   // receiver hold-off for the backpressure test
    localparam int TAIL_CYCLES    = 16;    // latency plus the longest burst of one word
    localparam int MAX_REPORTS    = 40;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_payload_byte   = '0;
    logic [BYTE_W-1:0]   i_sequence_req   = '0;
    logic [LEN_W-1:0]    i_payload_length = '0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_last_of_item;
    logic                o_end_of_frame;

    ota_data_frame_builder_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_payload_byte   (i_payload_byte),
        .i_sequence_req   (i_sequence_req),
        .i_payload_length (i_payload_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_last_of_item   (o_last_of_item),
        .o_end_of_frame   (o_end_of_frame)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Frame bytes predicted but not yet seen on the output, oldest first.
    t_emit due_bytes[$];

    // Predicted builder state.
    bit                frm_open = 1'b0;
    logic [LEN_W-1:0]  frm_left = '0;
    logic [SUM_W-1:0]  frm_sum  = '0;

    int  mismatches   = 0;
    int  bytes_seen   = 0;
    int  words_sent   = 0;
    int  idle_cycles  = 0;

    // Idling switches for each side; both are turned off for the closing stretch.
    bit  tx_idling    = 1'b1;
    bit  rx_idling    = 1'b1;

    // A long receiver hold is requested by bumping hold_requests; the receiver
    // process notices the change and counts the hold out on its own.
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  rx_wait       = 0;

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on frame byte %0d: %s expected %0h got %0h",
                     bytes_seen, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Frame predictor.
    // ------------------------------------------------------------------

    function automatic void push_frame_byte(input logic [BYTE_W-1:0] b, input bit summed,
                                            input bit frame_end);
        t_emit e;
        e.out_byte     = b;
        e.last_of_item = 1'b0;
        e.end_of_frame = frame_end;
        due_bytes.push_back(e);
        if (summed) begin
            frm_sum = frm_sum + 16'(b);
        end
    endfunction

    // Checksum, then the FF FC FF FF trailer; the frame closes and the sum restarts.
    function automatic void push_trailer();
        logic [SUM_W-1:0] ck;
        ck = 16'hFFFF - frm_sum;
        push_frame_byte(ck[15:8], 1'b0, 1'b0);
        push_frame_byte(ck[7:0], 1'b0, 1'b0);
        push_frame_byte(EOF_A_BYTE, 1'b0, 1'b0);
        push_frame_byte(EOF_B_BYTE, 1'b0, 1'b0);
        push_frame_byte(EOF_A_BYTE, 1'b0, 1'b0);
        push_frame_byte(EOF_A_BYTE, 1'b0, 1'b1);
        frm_open = 1'b0;
        frm_left = '0;
        frm_sum  = '0;
    endfunction

    function automatic void build_frame_bytes(input logic [BYTE_W-1:0] data,
                                              input logic [BYTE_W-1:0] seq,
                                              input logic [LEN_W-1:0]  len_req);
        logic [LEN_W-1:0] plen;
        logic [SUM_W-1:0] flen;
        t_emit            e;
        if (!frm_open) begin
            // Lengths above the maximum are clipped before they reach the header.
            plen = (int'(len_req) > MAX_PAYLOAD_DEF) ? LEN_W'(MAX_PAYLOAD_DEF) : len_req;
            flen = LEN_OFFSET + 16'(plen);
            frm_sum = '0;
            push_frame_byte(SOF_BYTE, 1'b0, 1'b0);
            push_frame_byte(ID_BYTE, 1'b1, 1'b0);
            push_frame_byte(flen[15:8], 1'b1, 1'b0);
            push_frame_byte(flen[7:0], 1'b1, 1'b0);
            push_frame_byte(CMD_H_BYTE, 1'b1, 1'b0);
            push_frame_byte(CMD_L_BYTE, 1'b1, 1'b0);
            push_frame_byte(seq, 1'b1, 1'b0);
            if (plen == '0) begin
                // Empty frame: the payload byte of this word is dropped.
                push_trailer();
            end else begin
                push_frame_byte(data, 1'b1, 1'b0);
                if (plen == LEN_W'(1)) begin
                    push_trailer();
                end else begin
                    frm_open = 1'b1;
                    frm_left = plen - LEN_W'(1);
                end
            end
        end else begin
            push_frame_byte(data, 1'b1, 1'b0);
            if (frm_left <= LEN_W'(1)) begin
                push_trailer();
            end else begin
                frm_left = frm_left - LEN_W'(1);
            end
        end
        // The newest byte is the last one this word causes.
        e = due_bytes.pop_back();
        e.last_of_item = 1'b1;
        due_bytes.push_back(e);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks each accepted output word, predicts for each accepted
    // input word, and runs the watchdog. Everything samples the values from
    // before the edge, so the order against the drivers does not matter.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_emit want;
        bit    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (due_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", 0, o_out_byte);
                end else begin
                    want = due_bytes.pop_front();
                    if (o_out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, o_out_byte);
                    if (o_last_of_item !== want.last_of_item)
                        report_mismatch("last_of_item", want.last_of_item, o_last_of_item);
                    if (o_end_of_frame !== want.end_of_frame)
                        report_mismatch("end_of_frame", want.end_of_frame, o_end_of_frame);
                end
                bytes_seen++;
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                build_frame_bytes(i_payload_byte, i_sequence_req, i_payload_length);
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("tb_top NOT OK");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus long holds on request.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rx_wait = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else if (rx_idling && $urandom_range(0, 5) == 0) begin
            rx_wait = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender. send_word returns at the edge that accepted the word with valid
    // still high; the next call either replaces the payload in the same step
    // or drops valid for an idle burst. Anything that waits drops valid first.
    // ------------------------------------------------------------------

    task automatic send_word(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] seq,
                             input logic [LEN_W-1:0] len_req);
        int gap;
        if (tx_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_payload_byte   <= data;
        i_sequence_req   <= seq;
        i_payload_length <= len_req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Byte values lean toward the extremes so the sum wraps and every bit toggles.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One well-formed frame with random content. Words after the first carry
    // random sequence and length fields, which the block must ignore.
    task automatic send_random_frame();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 22)
            len = 1;
        else if (pick < 85)
            len = $urandom_range(2, 16);
        else
            len = $urandom_range(17, 80);
        send_word(pick_byte(), pick_byte(), LEN_W'(len));
        for (int k = 1; k < len; k++) begin
            send_word(pick_byte(), pick_byte(), LEN_W'($urandom_range(0, 1023)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Empty and one-byte frames at the byte extremes, then short frames whose
    // later words carry noise in the ignored fields.
    task automatic test_short_frames();
        send_word(8'hFF, 8'hFF, LEN_W'(0));
        send_word(8'h00, 8'h00, LEN_W'(0));
        send_word(8'hFF, 8'h80, LEN_W'(1));
        send_word(8'h00, 8'h7F, LEN_W'(1));
        send_word(8'hFF, 8'h01, LEN_W'(2));
        send_word(8'hFF, 8'hFE, 10'h3FF);
        send_word(8'h00, 8'h55, LEN_W'(3));
        send_word(8'h01, 8'hAA, 10'h000);
        send_word(8'hFE, 8'h00, 10'h200);
        send_word(8'h5A, 8'hC3, LEN_W'(2));
        send_word(8'hA5, 8'h3C, 10'h155);
        wait_drained();
    endtask

    // A length far above the maximum: the header carries 5 plus the maximum and
    // exactly the maximum number of payload words follow. High bytes make the
    // running sum wrap once.
    task automatic test_saturated_length();
        send_word(8'hFF, 8'h96, 10'h3FF);
        for (int k = 1; k < MAX_PAYLOAD_DEF; k++) begin
            send_word(8'($urandom_range(128, 255)), pick_byte(), LEN_W'($urandom_range(0, 1023)));
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // words back to back, so the block fills and stalls its input. The sender then
    // pauses until every predicted byte has come out.
    task automatic test_output_backpressure();
        tx_idling = 1'b0;
        hold_requests++;
        send_word(pick_byte(), 8'h42, LEN_W'(16));
        for (int k = 1; k < 16; k++) begin
            send_word(pick_byte(), pick_byte(), LEN_W'($urandom_range(0, 1023)));
        end
        wait_drained();
        // Empty frames turn each word into a whole frame, so they back up the input quickly.
        hold_requests++;
        for (int k = 0; k < 6; k++) begin
            send_word(pick_byte(), pick_byte(), LEN_W'(0));
        end
        wait_drained();
        tx_idling = 1'b1;
    endtask

    task automatic test_random_frames(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target) begin
            send_random_frame();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_saturated_length();
        test_output_backpressure();
        test_random_frames(20);
        // Closing stretch at full rate on both sides.
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_frames(20);
        wait_drained();

        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
